### rtl/assert_macros.svh
// assertion helpers used by ordered_array_list_top
// every check samples on clk and is held off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every sampled edge
`define OLA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger in one cycle implies a consequence in the same cycle
`define OLA_ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// trigger in one cycle implies a consequence in the next cycle
`define OLA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/ola_pkg.sv
package ola_pkg;

  // request kinds
  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_DELETE   = 2'd1;
  localparam logic [1:0] KIND_RETRIEVE = 2'd2;
  localparam logic [1:0] KIND_CLEAR    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_BAD_POS  = 2'd3;

  // position operand and neighbor fields
  localparam int POS_W = 7;
  localparam logic signed [POS_W-1:0] NO_POS = 7'sh7F;

  typedef logic signed [POS_W-1:0] pos_t;

endpackage

### rtl/ordered_array_list_top.sv
// Ordered list of up to CAPACITY entries kept at positions 0..count-1 in one
// single-port-write, single-port-read RAM. A request is insert after pos
// (pos -1 places at the front), delete at pos, retrieve at pos or clear, and
// each request returns exactly one result transaction carrying status, the
// retrieved entry with its neighbor positions, and the new count with empty
// and full flags. On any error the list is left as it was. The block works on
// one request at a time and holds in_stall high from acceptance until the
// result is loaded into the output register. Insert and delete move the
// entries behind pos one RAM slot per cycle through a read-then-write
// pipeline on the RAM ports. An insert or delete that moves entries issues
// one read per moved entry, one trailing write, a closing step that writes
// the new entry or ends the delete, and the result load; retrieve, clear and
// every error go straight to the result load. The result register frees the
// block as soon as the result is loaded, so a new request can be taken while
// the previous result still waits for the consumer. No clearing pass runs
// after reset: only slots below count are ever read.
`include "assert_macros.svh"

module ordered_array_list_top import ola_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic signed [6:0] pos,
  input  logic [31:0]       entry,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [31:0]       entry_out,
  output logic signed [6:0] prev_pos,
  output logic signed [6:0] next_pos,
  output logic [6:0]        count,
  output logic              is_empty,
  output logic              is_full
);

  // ram address width, count width, and a compare width wide enough for pos
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = ENTRY_WIDTH;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_UP    = 2'd1; // shift entries up for insert
  localparam logic [1:0] S_DOWN  = 2'd2; // shift entries down for delete
  localparam logic [1:0] S_FIN   = 2'd3; // load result register

  logic [1:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] src, src_next;         // next slot to read during a shift
  logic [AW-1:0] wr_ptr, wr_ptr_next;   // next slot to write during a shift
  logic [CW-1:0] rd_left, rd_left_next; // reads still to issue
  logic          pend, pend_next;       // read data in flight to be written
  logic [AW-1:0] slot, slot_next;       // insert target slot
  logic [EW-1:0] ins_val, ins_val_next;
  logic [1:0]    res_status, res_status_next;
  pos_t          res_prev, res_prev_next;
  pos_t          res_next, res_next_next;
  logic          use_rd, use_rd_next;

  // ram ports
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [EW-1:0] ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [EW-1:0] ram_rd_data;

  logic          in_acc;
  logic          out_load;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [AW-1:0] pos_a;
  logic          pos_valid;
  logic          pos_front;
  logic          list_full;
  logic [63:0]   entry_wide;
  logic [63:0]   rd_wide;
  logic          ram_both;  // read and write issued in one cycle
  logic          shifting;  // a shift read is due this cycle

  ola_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // result register is free when empty or being taken this cycle
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  // position decode against the current count
  assign pos_x      = XW'(pos[5:0]);
  assign cnt_x      = XW'(cnt);
  assign pos_a      = pos_x[AW-1:0];
  assign pos_valid  = !pos[6] && (pos_x < cnt_x);
  assign pos_front  = (pos == NO_POS);
  assign list_full  = (cnt_x >= XW'(CAPACITY));
  assign entry_wide = 64'(entry);
  assign rd_wide    = 64'(ram_rd_data);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    src_next        = src;
    wr_ptr_next     = wr_ptr;
    rd_left_next    = rd_left;
    pend_next       = 1'b0;
    slot_next       = slot;
    ins_val_next    = ins_val;
    res_status_next = res_status;
    res_prev_next   = res_prev;
    res_next_next   = res_next;
    use_rd_next     = use_rd;

    ram_wr_en   = 1'b0;
    ram_wr_addr = wr_ptr;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = src;

    case (state)
      S_IDLE: begin
        ram_rd_addr = pos_a;
        if (in_acc) begin
          res_status_next = ST_OK;
          res_prev_next   = NO_POS;
          res_next_next   = NO_POS;
          use_rd_next     = 1'b0;
          state_next      = S_FIN;
          case (kind)
            KIND_INSERT: begin
              if (list_full) begin
                res_status_next = ST_OVERFLOW;
              end else if (!pos_valid && !pos_front) begin
                res_status_next = ST_BAD_POS;
              end else begin
                // move slots count-1 .. slot up by one, then write slot
                slot_next    = pos_front ? '0 : AW'(pos_x + XW'(1));
                rd_left_next = pos_front ? cnt : CW'(cnt_x - pos_x - XW'(1));
                src_next     = AW'(cnt_x - XW'(1));
                wr_ptr_next  = cnt_x[AW-1:0];
                ins_val_next = entry_wide[EW-1:0];
                cnt_next     = CW'(cnt_x + XW'(1));
                state_next   = S_UP;
              end
            end
            KIND_DELETE: begin
              if (cnt == '0) begin
                res_status_next = ST_EMPTY;
              end else if (!pos_valid) begin
                res_status_next = ST_BAD_POS;
              end else begin
                // move slots pos+1 .. count-1 down by one
                rd_left_next = CW'(cnt_x - pos_x - XW'(1));
                src_next     = AW'(pos_x + XW'(1));
                wr_ptr_next  = pos_a;
                cnt_next     = CW'(cnt_x - XW'(1));
                state_next   = S_DOWN;
              end
            end
            KIND_RETRIEVE: begin
              if (!pos_valid) begin
                res_status_next = ST_BAD_POS;
              end else begin
                ram_rd_en     = 1'b1;
                use_rd_next   = 1'b1;
                res_prev_next = (pos == 7'sd0) ? NO_POS : pos - 7'sd1;
                res_next_next = ((pos_x + XW'(1)) == cnt_x) ? NO_POS : pos + 7'sd1;
              end
            end
            KIND_CLEAR: begin
              cnt_next = '0;
            end
            default: begin
              res_status_next = ST_OK;
            end
          endcase
        end
      end

      S_UP: begin
        if (rd_left != '0) begin
          ram_rd_en    = 1'b1;
          src_next     = src - AW'(1);
          rd_left_next = rd_left - CW'(1);
          pend_next    = 1'b1;
        end
        if (pend) begin
          ram_wr_en   = 1'b1;
          wr_ptr_next = wr_ptr - AW'(1);
        end else if (rd_left == '0) begin
          // all moves done, drop the new entry into its slot
          ram_wr_en   = 1'b1;
          ram_wr_addr = slot;
          ram_wr_data = ins_val;
          state_next  = S_FIN;
        end
      end

      S_DOWN: begin
        if (rd_left != '0) begin
          ram_rd_en    = 1'b1;
          src_next     = src + AW'(1);
          rd_left_next = rd_left - CW'(1);
          pend_next    = 1'b1;
        end
        if (pend) begin
          ram_wr_en   = 1'b1;
          wr_ptr_next = wr_ptr + AW'(1);
        end else if (rd_left == '0) begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      rd_left   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      pend    <= pend_next;
      rd_left <= rd_left_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    src        <= src_next;
    wr_ptr     <= wr_ptr_next;
    slot       <= slot_next;
    ins_val    <= ins_val_next;
    res_status <= res_status_next;
    res_prev   <= res_prev_next;
    res_next   <= res_next_next;
    use_rd     <= use_rd_next;
    // result register, count already reflects this request
    if (out_load) begin
      status    <= res_status;
      entry_out <= use_rd ? rd_wide[31:0] : 32'd0;
      prev_pos  <= res_prev;
      next_pos  <= res_next;
      count     <= cnt_x[6:0];
      is_empty  <= (cnt == '0);
      is_full   <= (cnt_x == XW'(CAPACITY));
    end
  end

  assign ram_both = ram_wr_en && ram_rd_en;
  assign shifting = (state == S_UP || state == S_DOWN) && (rd_left != '0);

  `OLA_ASSERT_ALWAYS(a_cnt_bound, cnt_x <= XW'(CAPACITY), "entry count above capacity")
  `OLA_ASSERT_NEXT(a_acc_busy, in_acc, state != S_IDLE, "block idle right after a request")
  `OLA_ASSERT_SAME(a_ram_rw, ram_both, ram_wr_addr != ram_rd_addr, "ram read and write on one slot")
  `OLA_ASSERT_NEXT(a_shift_step, shifting, pend && rd_left == $past(rd_left) - CW'(1), "shift stuck")

endmodule

### rtl/ola_ram.sv
module ola_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
